// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, disabled during reset.
`define PCI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, disabled during reset.
`define PCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pci2d_pkg.sv =====
package pci2d_pkg;

  localparam int unsigned VW    = 32;         // velocity width
  localparam int unsigned NRMW  = 16;         // normal component width
  localparam int unsigned IMW   = 32;         // inverse mass width
  localparam int unsigned RSTW  = 16;         // restitution width
  localparam int unsigned RXW   = VW + 1;     // relative velocity
  localparam int unsigned PW    = RXW + NRMW; // one dot product term
  localparam int unsigned SEPW  = PW + 1;     // separating speed, 30 fraction bits
  localparam int unsigned M16W  = SEPW - 14;  // speed magnitude, 16 fraction bits
  localparam int unsigned FACW  = RSTW + 1;   // 1 + restitution, Q2.15
  localparam int unsigned DVW   = M16W + FACW;
  localparam int unsigned DLW   = 32;
  localparam int unsigned DHW   = DVW - DLW;
  localparam int unsigned NPW   = DVW + IMW;  // full share numerator
  localparam int unsigned NSH   = 15;
  localparam int unsigned NW    = NPW - NSH;  // numerator after the 2^15 scale
  localparam int unsigned TW    = IMW + 1;    // total inverse mass
  localparam int unsigned RW    = TW + 1;     // divider remainder
  localparam int unsigned QW    = 38;         // quotient bits
  localparam int unsigned ZW    = RW + QW;
  localparam int unsigned CPW   = QW + 1 + NRMW;
  localparam int unsigned CHW   = CPW - 14;
  localparam int unsigned SUMW  = CHW + 1;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [RSTW-1:0] REST_RESET = 16'h8000;
  localparam logic [FACW-1:0] FAC_ONE    = 17'h08000;
  localparam logic [CPW-1:0]  RND_HALF   = CPW'(8192);

  typedef enum logic [1:0] {
    ST_SEP  = 2'd0,
    ST_IMP  = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [VW-1:0]   v0x;
    logic signed [VW-1:0]   v0y;
    logic signed [VW-1:0]   v1x;
    logic signed [VW-1:0]   v1y;
    logic        [IMW-1:0]  im0;
    logic        [IMW-1:0]  im1;
    logic signed [NRMW-1:0] nx;
    logic signed [NRMW-1:0] ny;
    logic        [M16W-1:0] m16;
    status_e                status;
    logic                   two;
  } item_t;

  typedef struct packed {
    logic signed [VW-1:0]   v0x;
    logic signed [VW-1:0]   v0y;
    logic signed [VW-1:0]   v1x;
    logic signed [VW-1:0]   v1y;
    logic signed [NRMW-1:0] nx;
    logic signed [NRMW-1:0] ny;
    status_e                status;
    logic                   two;
  } ctx_t;

  // One restoring division step: shift in the next numerator bit, trial subtract.
  function automatic logic [ZW-1:0] div_step(input logic [ZW-1:0] z,
                                             input logic [TW-1:0] den);
    logic [RW-1:0] rs;
    logic          qb;
    rs = {z[ZW-2:QW], z[QW-1]};
    qb = 1'b0;
    if (rs >= {1'b0, den}) begin
      rs = rs - {1'b0, den};
      qb = 1'b1;
    end
    return {rs, z[QW-2:0], qb};
  endfunction

  // Rounded normal-direction change from a share times a normal component.
  function automatic logic signed [CHW-1:0] comp_change(input logic [QW-1:0] q,
                                                       input logic signed [NRMW-1:0] n);
    logic signed [CPW-1:0] p;
    logic signed [CPW-1:0] t;
    p = CPW'($signed({1'b0, q})) * CPW'(n);
    t = p + $signed(RND_HALF);
    return $signed(t[CPW-1:14]);
  endfunction

  function automatic logic signed [VW-1:0] sat32(input logic signed [SUMW-1:0] v);
    if ((&v[SUMW-1:VW-1]) || !(|v[SUMW-1:VW-1])) begin
      return v[VW-1:0];
    end
    return v[SUMW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
  endfunction

endpackage

// ===== hdl/pci2d_front.sv =====
module pci2d_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [pci2d_pkg::VW-1:0]      vel0_x_i,
  input  logic signed [pci2d_pkg::VW-1:0]      vel0_y_i,
  input  logic signed [pci2d_pkg::VW-1:0]      vel1_x_i,
  input  logic signed [pci2d_pkg::VW-1:0]      vel1_y_i,
  input  logic        [pci2d_pkg::IMW-1:0]     inv_mass0_i,
  input  logic        [pci2d_pkg::IMW-1:0]     inv_mass1_i,
  input  logic signed [pci2d_pkg::NRMW-1:0]    normal_x_i,
  input  logic signed [pci2d_pkg::NRMW-1:0]    normal_y_i,
  input  logic                                 has_second_i,
  input  logic                                 full_i,
  output logic                                 push_o,
  output pci2d_pkg::item_t                     item_o
);

  logic                                    f_valid_q;
  logic                                    f_adv;
  logic signed [pci2d_pkg::RXW-1:0]        rx;
  logic signed [pci2d_pkg::RXW-1:0]        ry;
  logic signed [pci2d_pkg::PW-1:0]         px_d, px_q;
  logic signed [pci2d_pkg::PW-1:0]         py_d, py_q;
  logic                                    tzero_d, tzero_q;
  logic signed [pci2d_pkg::SEPW-1:0]       sep;
  logic signed [pci2d_pkg::SEPW-1:0]       msep;
  pci2d_pkg::item_t                        it_q;

  assign f_adv      = !f_valid_q || !full_i;
  assign in_stall_o = f_valid_q && full_i;
  assign push_o     = f_valid_q && !full_i;

  always_comb begin
    rx = pci2d_pkg::RXW'(vel0_x_i) - (has_second_i ? pci2d_pkg::RXW'(vel1_x_i) : '0);
    ry = pci2d_pkg::RXW'(vel0_y_i) - (has_second_i ? pci2d_pkg::RXW'(vel1_y_i) : '0);
    px_d = pci2d_pkg::PW'(rx) * pci2d_pkg::PW'(normal_x_i);
    py_d = pci2d_pkg::PW'(ry) * pci2d_pkg::PW'(normal_y_i);
    tzero_d = (inv_mass0_i == '0) && (!has_second_i || (inv_mass1_i == '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (f_adv) begin
      f_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_adv) begin
      px_q         <= px_d;
      py_q         <= py_d;
      tzero_q      <= tzero_d;
      it_q.v0x     <= vel0_x_i;
      it_q.v0y     <= vel0_y_i;
      it_q.v1x     <= vel1_x_i;
      it_q.v1y     <= vel1_y_i;
      it_q.im0     <= inv_mass0_i;
      it_q.im1     <= has_second_i ? inv_mass1_i : '0;
      it_q.nx      <= normal_x_i;
      it_q.ny      <= normal_y_i;
      it_q.m16     <= '0;
      it_q.status  <= pci2d_pkg::ST_SEP;
      it_q.two     <= has_second_i;
    end
  end

  // Classify: apart, no movable mass, or an impulse to share.
  always_comb begin
    sep  = pci2d_pkg::SEPW'(px_q) + pci2d_pkg::SEPW'(py_q);
    msep = -sep;
    item_o     = it_q;
    item_o.m16 = msep[pci2d_pkg::SEPW-1:14];
    priority if (!sep[pci2d_pkg::SEPW-1] && (sep != '0)) begin
      item_o.status = pci2d_pkg::ST_SEP;
    end else if (tzero_q) begin
      item_o.status = pci2d_pkg::ST_ZERO;
    end else begin
      item_o.status = pci2d_pkg::ST_IMP;
    end
  end

endmodule

// ===== hdl/pci2d_queue.sv =====
module pci2d_queue #(
  parameter int unsigned DEPTH = pci2d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pci2d_pkg::item_t item_i,
  output logic             full_o,
  output logic             empty_o,
  input  logic             pop_i,
  output pci2d_pkg::item_t item_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pci2d_pkg::item_t mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== hdl/pci2d_divider.sv =====
module pci2d_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [pci2d_pkg::NW-1:0]      n0_i,
  input  logic [pci2d_pkg::NW-1:0]      n1_i,
  input  logic [pci2d_pkg::TW-1:0]      den_i,
  input  pci2d_pkg::ctx_t               ctx_i,
  output logic                          valid_o,
  output logic [pci2d_pkg::QW-1:0]      q0_o,
  output logic [pci2d_pkg::QW-1:0]      q1_o,
  output pci2d_pkg::ctx_t               ctx_o
);

  localparam int unsigned QW = pci2d_pkg::QW;
  localparam int unsigned RW = pci2d_pkg::RW;
  localparam int unsigned ZW = pci2d_pkg::ZW;
  localparam int unsigned NW = pci2d_pkg::NW;

  logic [ZW-1:0]               z0_q  [QW];
  logic [ZW-1:0]               z1_q  [QW];
  logic [pci2d_pkg::TW-1:0]    den_q [QW];
  pci2d_pkg::ctx_t             ctx_q [QW];
  logic [QW-1:0]               vld_q;
  logic [ZW-1:0]               z0_init, z1_init;

  // The quotient fits QW bits, so the bits above them start as the remainder.
  assign z0_init = {RW'(n0_i[NW-1:QW]), n0_i[QW-1:0]};
  assign z1_init = {RW'(n1_i[NW-1:QW]), n1_i[QW-1:0]};

  for (genvar k = 0; k < QW; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (en_i) begin
          vld_q[k] <= valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z0_q[k]  <= pci2d_pkg::div_step(z0_init, den_i);
          z1_q[k]  <= pci2d_pkg::div_step(z1_init, den_i);
          den_q[k] <= den_i;
          ctx_q[k] <= ctx_i;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (en_i) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z0_q[k]  <= pci2d_pkg::div_step(z0_q[k-1], den_q[k-1]);
          z1_q[k]  <= pci2d_pkg::div_step(z1_q[k-1], den_q[k-1]);
          den_q[k] <= den_q[k-1];
          ctx_q[k] <= ctx_q[k-1];
        end
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign q0_o    = z0_q[QW-1][QW-1:0];
  assign q1_o    = z1_q[QW-1][QW-1:0];
  assign ctx_o   = ctx_q[QW-1];

endmodule

// ===== hdl/pci2d_back.sv =====
module pci2d_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               avail_i,
  input  pci2d_pkg::item_t                   item_i,
  output logic                               pop_o,
  input  logic [pci2d_pkg::RSTW-1:0]         restitution_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [pci2d_pkg::VW-1:0]    new_vel0_x_o,
  output logic signed [pci2d_pkg::VW-1:0]    new_vel0_y_o,
  output logic signed [pci2d_pkg::VW-1:0]    new_vel1_x_o,
  output logic signed [pci2d_pkg::VW-1:0]    new_vel1_y_o,
  output logic [1:0]                         status_o
);

  localparam int unsigned DVW  = pci2d_pkg::DVW;
  localparam int unsigned DLW  = pci2d_pkg::DLW;
  localparam int unsigned NPW  = pci2d_pkg::NPW;
  localparam int unsigned NSH  = pci2d_pkg::NSH;
  localparam int unsigned IMW  = pci2d_pkg::IMW;
  localparam int unsigned TW   = pci2d_pkg::TW;
  localparam int unsigned SUMW = pci2d_pkg::SUMW;

  logic                                adv;
  logic                                a_v_q, b_v_q, c_v_q, m_v_q, out_valid_q;
  pci2d_pkg::item_t                    a_it_q, b_it_q;
  logic [DVW-1:0]                      dv_q;
  logic [pci2d_pkg::FACW-1:0]          fac;
  logic [DLW+IMW-1:0]                  pl0_q, pl1_q;
  logic [DVW-DLW+IMW-1:0]              ph0_q, ph1_q;
  logic [NPW-1:0]                      nf0, nf1;
  logic [pci2d_pkg::NW-1:0]            n0_q, n1_q;
  logic [TW-1:0]                       tot_q;
  pci2d_pkg::ctx_t                     c_ctx_q, d_ctx, m_ctx_q;
  logic                                d_valid;
  logic [pci2d_pkg::QW-1:0]            q0, q1;
  logic signed [pci2d_pkg::CHW-1:0]    c0x_q, c0y_q, c1x_q, c1y_q;
  logic signed [SUMW-1:0]              s0x, s0y, s1x, s1y;
  logic signed [pci2d_pkg::VW-1:0]     o0x_d, o0y_d, o1x_d, o1y_d;
  logic signed [pci2d_pkg::VW-1:0]     o0x_q, o0y_q, o1x_q, o1y_q;
  logic [1:0]                          st_q;

  // Freeze the whole pipeline while a finished result is held.
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && avail_i;
  assign fac   = pci2d_pkg::FAC_ONE + pci2d_pkg::FACW'(restitution_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q       <= 1'b0;
      b_v_q       <= 1'b0;
      c_v_q       <= 1'b0;
      m_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_v_q       <= pop_o;
      b_v_q       <= a_v_q;
      c_v_q       <= b_v_q;
      m_v_q       <= d_valid;
      out_valid_q <= m_v_q;
    end
  end

  always_comb begin
    nf0 = NPW'(pl0_q) + (NPW'(ph0_q) << DLW);
    nf1 = NPW'(pl1_q) + (NPW'(ph1_q) << DLW);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_it_q <= item_i;
      dv_q   <= DVW'(item_i.m16) * DVW'(fac);
      b_it_q <= a_it_q;
      pl0_q  <= (DLW+IMW)'(dv_q[DLW-1:0]) * (DLW+IMW)'(a_it_q.im0);
      pl1_q  <= (DLW+IMW)'(dv_q[DLW-1:0]) * (DLW+IMW)'(a_it_q.im1);
      ph0_q  <= (DVW-DLW+IMW)'(dv_q[DVW-1:DLW]) * (DVW-DLW+IMW)'(a_it_q.im0);
      ph1_q  <= (DVW-DLW+IMW)'(dv_q[DVW-1:DLW]) * (DVW-DLW+IMW)'(a_it_q.im1);
      n0_q   <= nf0[NPW-1:NSH];
      n1_q   <= nf1[NPW-1:NSH];
      tot_q  <= TW'(b_it_q.im0) + TW'(b_it_q.im1);
      c_ctx_q.v0x    <= b_it_q.v0x;
      c_ctx_q.v0y    <= b_it_q.v0y;
      c_ctx_q.v1x    <= b_it_q.v1x;
      c_ctx_q.v1y    <= b_it_q.v1y;
      c_ctx_q.nx     <= b_it_q.nx;
      c_ctx_q.ny     <= b_it_q.ny;
      c_ctx_q.status <= b_it_q.status;
      c_ctx_q.two    <= b_it_q.two;
      m_ctx_q <= d_ctx;
      c0x_q   <= pci2d_pkg::comp_change(q0, d_ctx.nx);
      c0y_q   <= pci2d_pkg::comp_change(q0, d_ctx.ny);
      c1x_q   <= pci2d_pkg::comp_change(q1, d_ctx.nx);
      c1y_q   <= pci2d_pkg::comp_change(q1, d_ctx.ny);
      o0x_q   <= o0x_d;
      o0y_q   <= o0y_d;
      o1x_q   <= o1x_d;
      o1y_q   <= o1y_d;
      st_q    <= m_ctx_q.status;
    end
  end

  pci2d_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (c_v_q),
    .n0_i    (n0_q),
    .n1_i    (n1_q),
    .den_i   (tot_q),
    .ctx_i   (c_ctx_q),
    .valid_o (d_valid),
    .q0_o    (q0),
    .q1_o    (q1),
    .ctx_o   (d_ctx)
  );

  always_comb begin
    s0x = SUMW'(m_ctx_q.v0x) + SUMW'(c0x_q);
    s0y = SUMW'(m_ctx_q.v0y) + SUMW'(c0y_q);
    s1x = SUMW'(m_ctx_q.v1x) - SUMW'(c1x_q);
    s1y = SUMW'(m_ctx_q.v1y) - SUMW'(c1y_q);
    o0x_d = m_ctx_q.v0x;
    o0y_d = m_ctx_q.v0y;
    o1x_d = m_ctx_q.v1x;
    o1y_d = m_ctx_q.v1y;
    unique case (m_ctx_q.status)
      pci2d_pkg::ST_IMP: begin
        o0x_d = pci2d_pkg::sat32(s0x);
        o0y_d = pci2d_pkg::sat32(s0y);
        if (m_ctx_q.two) begin
          o1x_d = pci2d_pkg::sat32(s1x);
          o1y_d = pci2d_pkg::sat32(s1y);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign new_vel0_x_o = o0x_q;
  assign new_vel0_y_o = o0y_q;
  assign new_vel1_x_o = o1x_q;
  assign new_vel1_y_o = o1y_q;
  assign status_o     = st_q;

endmodule

// ===== hdl/particle_contact_impulse_2d.sv =====
// Particle contact impulse resolution, 2D, fixed point.
// Input channel (in_valid_i / in_stall_o): one contact per transaction, with
// both velocities, inverse masses, the unit normal and has_second_i.
// Output channel (out_valid_o / out_stall_i): one result per contact, in
// order: updated velocities (saturated) and a status code.
// Config channel (cfg_valid_i / cfg_ready_o): writes the Q1.15 restitution;
// always ready; write only while no contact is in flight.
// Throughput: one contact per cycle while in_stall_o is low. Path: front, queue,
// back stages, the 38-stage share divider, change and output registers.
// A front stage classifies each contact and hands it through a short queue
// to the back pipeline; when the receiver stalls, the back pipeline holds,
// the queue fills, and only then in_stall_o rises.
// Reset clears all valid state and sets restitution to 1.0.
`include "assert_macros.svh"

module particle_contact_impulse_2d #(
  parameter int unsigned QUEUE_DEPTH = pci2d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pci2d_pkg::RSTW-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [pci2d_pkg::VW-1:0]     vel0_x_i,
  input  logic signed [pci2d_pkg::VW-1:0]     vel0_y_i,
  input  logic signed [pci2d_pkg::VW-1:0]     vel1_x_i,
  input  logic signed [pci2d_pkg::VW-1:0]     vel1_y_i,
  input  logic        [pci2d_pkg::IMW-1:0]    inv_mass0_i,
  input  logic        [pci2d_pkg::IMW-1:0]    inv_mass1_i,
  input  logic signed [pci2d_pkg::NRMW-1:0]   normal_x_i,
  input  logic signed [pci2d_pkg::NRMW-1:0]   normal_y_i,
  input  logic                                has_second_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pci2d_pkg::VW-1:0]     new_vel0_x_o,
  output logic signed [pci2d_pkg::VW-1:0]     new_vel0_y_o,
  output logic signed [pci2d_pkg::VW-1:0]     new_vel1_x_o,
  output logic signed [pci2d_pkg::VW-1:0]     new_vel1_y_o,
  output logic [1:0]                          status_o
);

  logic [pci2d_pkg::RSTW-1:0] rest_q;
  logic                       push, pop, q_full, q_empty;
  pci2d_pkg::item_t           f_item, q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q <= pci2d_pkg::REST_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rest_q <= cfg_data_i;
    end
  end

  pci2d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .vel0_x_i     (vel0_x_i),
    .vel0_y_i     (vel0_y_i),
    .vel1_x_i     (vel1_x_i),
    .vel1_y_i     (vel1_y_i),
    .inv_mass0_i  (inv_mass0_i),
    .inv_mass1_i  (inv_mass1_i),
    .normal_x_i   (normal_x_i),
    .normal_y_i   (normal_y_i),
    .has_second_i (has_second_i),
    .full_i       (q_full),
    .push_o       (push),
    .item_o       (f_item)
  );

  pci2d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (pop),
    .item_o  (q_item)
  );

  pci2d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .avail_i       (!q_empty),
    .item_i        (q_item),
    .pop_o         (pop),
    .restitution_i (rest_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .new_vel0_x_o  (new_vel0_x_o),
    .new_vel0_y_o  (new_vel0_y_o),
    .new_vel1_x_o  (new_vel1_x_o),
    .new_vel1_y_o  (new_vel1_y_o),
    .status_o      (status_o)
  );

  `PCI_ASSERT_NOW(a_no_overflow, push, !q_full, "queue written while full")
  `PCI_ASSERT_NOW(a_no_underflow, pop, !q_empty, "queue read while empty")
  `PCI_ASSERT_NEXT(a_stall_holds_front, in_stall_o && !pop, in_stall_o,
                   "front released without queue space")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned IDLE_LIMIT   = 20000;

  typedef struct {
    logic signed [31:0] v0x, v0y, v1x, v1y;
    logic [31:0]        im0, im1;
    logic signed [15:0] nx, ny;
    logic               two;
    bit                 hold_off; // wait for every result before this one goes out
  } contact_t;

  typedef struct {
    logic signed [31:0] v0x, v0y, v1x, v1y;
    logic [1:0]         status;
  } impulse_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] vel0_x_i = '0, vel0_y_i = '0, vel1_x_i = '0, vel1_y_i = '0;
  logic [31:0] inv_mass0_i = '0, inv_mass1_i = '0;
  logic signed [15:0] normal_x_i = '0, normal_y_i = '0;
  logic has_second_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] new_vel0_x_o, new_vel0_y_o, new_vel1_x_o, new_vel1_y_o;
  logic [1:0] status_o;

  always #5 clk_i = ~clk_i;

  particle_contact_impulse_2d dut (.*);

  contact_t  pending_contacts[$];
  impulse_t  expected_impulses[$];
  logic [15:0] bounce = 16'h8000;
  int errors = 0;
  int idle_cycles = 0;
  int impulses_seen = 0;
  int send_gap = 0;
  int stall_gap = 0;
  bit running = 1'b0;

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // floor((p + 2^13) / 2^14) on a signed value
  function automatic logic signed [127:0] round_change(input logic [127:0] q,
                                                       input logic signed [15:0] n);
    logic signed [127:0] p;
    p = $signed(q) * n + 128'sd8192;
    return p >>> 14;
  endfunction

  function automatic impulse_t resolve_contact(input contact_t c, input logic [15:0] rest);
    impulse_t r;
    logic signed [127:0] rx, ry, sep;
    logic [127:0] total, m16, dv, q0, q1;
    r.v0x = c.v0x; r.v0y = c.v0y; r.v1x = c.v1x; r.v1y = c.v1y;
    rx = c.v0x - (c.two ? c.v1x : 0);
    ry = c.v0y - (c.two ? c.v1y : 0);
    sep = rx * c.nx + ry * c.ny;
    total = {96'd0, c.im0} + (c.two ? {96'd0, c.im1} : 128'd0);
    if (sep > 0) begin
      r.status = pci2d_pkg::ST_SEP;
    end else if (total == 0) begin
      r.status = pci2d_pkg::ST_ZERO;
    end else begin
      m16 = 128'(-sep) >> 14;
      dv = m16 * (128'd32768 + rest);
      q0 = (dv * c.im0) / (total << 15);
      r.v0x = clamp32(c.v0x + round_change(q0, c.nx));
      r.v0y = clamp32(c.v0y + round_change(q0, c.ny));
      if (c.two) begin
        q1 = (dv * c.im1) / (total << 15);
        r.v1x = clamp32(c.v1x - round_change(q1, c.nx));
        r.v1y = clamp32(c.v1y - round_change(q1, c.ny));
      end
      r.status = pci2d_pkg::ST_IMP;
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_vel();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? $urandom_range(0, 65536 * 8)
                                     : -$urandom_range(0, 65536 * 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_mass();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hffffffff;
      2: return $urandom_range(1, 65536 * 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_normal();
    case ($urandom_range(0, 7))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      3: return 16'($urandom); // out of range, used as given
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic queue_contact(input logic [31:0] v0x, v0y, v1x, v1y, im0, im1,
                               input logic [15:0] nx, ny, input logic two);
    contact_t c;
    c.v0x = v0x; c.v0y = v0y; c.v1x = v1x; c.v1y = v1y;
    c.im0 = im0; c.im1 = im1; c.nx = nx; c.ny = ny; c.two = two;
    c.hold_off = 1'b0;
    pending_contacts.push_back(c);
  endtask

  task automatic queue_random(input int count);
    repeat (count)
      queue_contact(pick_vel(), pick_vel(), pick_vel(), pick_vel(), pick_mass(), pick_mass(),
                    pick_normal(), pick_normal(), 1'($urandom_range(0, 1)));
  endtask

  task automatic drain_and_settle();
    while (pending_contacts.size() != 0 || expected_impulses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_bounce(input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    bounce = value;
  endtask

  // Driver: present one contact per transaction, random gap before each
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      expected_impulses.push_back(resolve_contact(pending_contacts.pop_front(), bounce));
      send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) send_gap = 0;
    end
    if (send_gap > 0 && !(in_valid_i && in_stall_o)) send_gap = send_gap - 1;
    if (in_valid_i && in_stall_o) begin
      // hold the stalled payload
    end else if (running && send_gap == 0 && pending_contacts.size() != 0 &&
                 !(pending_contacts[0].hold_off && expected_impulses.size() != 0) &&
                 !(in_valid_i && !in_stall_o && pending_contacts.size() == 0)) begin
      in_valid_i   <= 1'b1;
      vel0_x_i     <= pending_contacts[0].v0x;
      vel0_y_i     <= pending_contacts[0].v0y;
      vel1_x_i     <= pending_contacts[0].v1x;
      vel1_y_i     <= pending_contacts[0].v1y;
      inv_mass0_i  <= pending_contacts[0].im0;
      inv_mass1_i  <= pending_contacts[0].im1;
      normal_x_i   <= pending_contacts[0].nx;
      normal_y_i   <= pending_contacts[0].ny;
      has_second_i <= pending_contacts[0].two;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Monitor: check each accepted transaction against the oldest expectation
  always @(posedge clk_i) begin
    impulse_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      impulses_seen = impulses_seen + 1;
      if (expected_impulses.size() == 0) begin
        $error("unexpected result transaction");
        errors = errors + 1;
      end else begin
        e = expected_impulses.pop_front();
        if (new_vel0_x_o !== e.v0x) begin
          $error("new_vel0_x expected %0d got %0d", e.v0x, new_vel0_x_o); errors++;
        end
        if (new_vel0_y_o !== e.v0y) begin
          $error("new_vel0_y expected %0d got %0d", e.v0y, new_vel0_y_o); errors++;
        end
        if (new_vel1_x_o !== e.v1x) begin
          $error("new_vel1_x expected %0d got %0d", e.v1x, new_vel1_x_o); errors++;
        end
        if (new_vel1_y_o !== e.v1y) begin
          $error("new_vel1_y expected %0d got %0d", e.v1y, new_vel1_y_o); errors++;
        end
        if (status_o !== e.status) begin
          $error("status expected %0d got %0d", e.status, status_o); errors++;
        end
      end
    end
    if (stall_gap > 0) begin
      stall_gap = stall_gap - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (out_valid_o && $urandom_range(0, 2) == 0) stall_gap = $urandom_range(0, 19);
    end
  end

  // Watchdog: count cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("particle_contact_impulse_2d test failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] settings[4];
    settings = '{16'd0, 16'h8000, 16'hffff, 16'h4000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: extremes, separating, zero mass, no second particle
    queue_contact(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                  32'hffffffff, 32'hffffffff, 16'sd16384, -16'sd16384, 1'b1);
    queue_contact(32'h10000, 0, 0, 0, 32'h10000, 32'h10000, 16'sd16384, 16'sd0, 1'b1);
    queue_contact(-32'sh10000, 0, 0, 0, 32'h10000, 32'h10000, 16'sd16384, 16'sd0, 1'b1);
    queue_contact(-32'sh10000, 0, 0, 0, 0, 0, 16'sd16384, 16'sd0, 1'b1);
    queue_contact(-32'sh10000, 0, 32'h5555, 32'haaaa, 32'h10000, 0, 16'sd16384, 16'sd0,
                  1'b0);
    queue_contact(0, 0, 0, 0, 32'h10000, 32'h10000, 16'sd0, 16'sd16384, 1'b1);
    queue_contact(0, 0, 32'h10000, 0, 0, 32'h10000, 16'sd16384, 16'sd0, 1'b1);
    queue_contact(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                  32'h1, 32'hffffffff, 16'sh7fff, 16'sh8000, 1'b1);
    queue_contact(-32'sh30000, 0, 0, 0, 0, 32'h10000, 16'sd16384, 16'sd0, 1'b0);
    queue_contact(32'hffffffff, 32'hffffffff, 32'h0, 32'h0, 32'hffffffff, 32'h0,
                  16'hffff, 16'hffff, 1'b1);
    running = 1'b1;
    drain_and_settle();
    foreach (settings[i]) begin
      write_bounce(settings[i]);
      queue_random(200);
      pending_contacts[100].hold_off = 1'b1;
      drain_and_settle();
    end
    write_bounce(16'($urandom));
    queue_random(200);
    drain_and_settle();
    $display("Checked %0d contacts: directed edge cases at the reset restitution,",
             impulses_seen);
    $display("then random contacts under five written restitution values.");
    if (errors == 0) $display("particle_contact_impulse_2d test passed");
    else $display("particle_contact_impulse_2d test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/pci2d_pkg.sv
hdl/pci2d_front.sv
hdl/pci2d_queue.sv
hdl/pci2d_divider.sv
hdl/pci2d_back.sv
hdl/particle_contact_impulse_2d.sv
bench/testbench.sv
